@@ rtl/apm_pkg.sv @@
// ----------------------------------------------------------------------------
// Attitude PD mixer package
// Shared widths, fixed-point constants, register indexes, state types and
// helper functions for the attitude estimator and motor mixer.
// ----------------------------------------------------------------------------
package apm_pkg;

    localparam int ANGLE_FRAC_BITS_DEF = 16;
    localparam int CORDIC_STEPS_DEF    = 16;
    localparam int TABLE_LEN           = 24;

    // Shared multiplier operand and product widths.
    localparam int MUL_A_W = 45;
    localparam int MUL_B_W = 20;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    // Tilt unit widths.
    localparam int RAD_W      = 48;
    localparam int SQRT_STEPS = RAD_W / 2;
    localparam int CORDIC_W   = 28;
    localparam int ZW         = 33;
    localparam int STEP_W     = 5;

    // Fixed-point constants.
    localparam logic [21:0] GYRO_STEP  = 22'd3908420;
    localparam logic [16:0] BLEND_OLD  = 17'd64225;
    localparam logic [10:0] BLEND_NEW  = 11'd1311;
    localparam logic [18:0] INV_DT     = 19'd315077;
    localparam logic [6:0]  TERM_LIMIT = 7'd85;
    localparam logic [20:0] DUTY_MAX   = 21'd2000000;
    localparam logic [20:0] DUTY_MIN   = 21'd1000000;

    // Configuration register indexes.
    localparam logic [2:0] REG_PROP_GAIN     = 3'd0;
    localparam logic [2:0] REG_DERIV_GAIN    = 3'd1;
    localparam logic [2:0] REG_BASE_THROTTLE = 3'd2;
    localparam logic [2:0] REG_MIX_GAIN      = 3'd3;
    localparam logic [2:0] REG_WARMUP_ITEMS  = 3'd4;

    // Configuration reset values.
    localparam logic [15:0] PROP_GAIN_RST     = 16'd4096;
    localparam logic [15:0] DERIV_GAIN_RST    = 16'd1229;
    localparam logic [20:0] BASE_THROTTLE_RST = 21'd1500000;
    localparam logic [15:0] MIX_GAIN_RST      = 16'd5880;
    localparam logic [7:0]  WARMUP_ITEMS_RST  = 8'd151;

    typedef enum logic [1:0] {
        T_IDLE,
        T_SQRT,
        T_CORDIC,
        T_DONE
    } tilt_state_t;

    typedef enum logic [4:0] {
        C_IDLE,
        C_GX,
        C_GY,
        C_GYW,
        C_S1,
        C_S2,
        C_S3,
        C_S4,
        C_TP,
        C_TPW,
        C_TR,
        C_TRW,
        C_B1,
        C_B2,
        C_B3,
        C_B4,
        C_B5,
        C_ERR,
        C_D1,
        C_D2,
        C_D3,
        C_D4,
        C_D5,
        C_M1,
        C_M2,
        C_M3,
        C_OUT
    } ctl_state_t;

    typedef struct packed {
        logic                    start;
        logic signed [15:0]      num;
        logic        [RAD_W-1:0] radicand;
    } tilt_req_t;

    typedef struct packed {
        logic                 done;
        logic signed [ZW-1:0] angle;
    } tilt_rsp_t;

    // Arctangent of 2^-i in degrees, Q24.
    function automatic logic [30:0] atan_deg_q24(input logic [STEP_W-1:0] i);
        logic [30:0] r;
        case (i)
            5'd0:    r = 31'd754974720;
            5'd1:    r = 31'd445687602;
            5'd2:    r = 31'd235489088;
            5'd3:    r = 31'd119537938;
            5'd4:    r = 31'd60000934;
            5'd5:    r = 31'd30029717;
            5'd6:    r = 31'd15018523;
            5'd7:    r = 31'd7509720;
            5'd8:    r = 31'd3754917;
            5'd9:    r = 31'd1877466;
            5'd10:   r = 31'd938734;
            5'd11:   r = 31'd469367;
            5'd12:   r = 31'd234684;
            5'd13:   r = 31'd117342;
            5'd14:   r = 31'd58671;
            5'd15:   r = 31'd29335;
            5'd16:   r = 31'd14668;
            5'd17:   r = 31'd7334;
            5'd18:   r = 31'd3667;
            5'd19:   r = 31'd1833;
            5'd20:   r = 31'd917;
            5'd21:   r = 31'd458;
            5'd22:   r = 31'd229;
            5'd23:   r = 31'd115;
            default: r = 31'd0;
        endcase
        return r;
    endfunction

    // Saturate to the signed 32-bit range.
    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        logic signed [31:0] r;
        if (v > 66'sd2147483647) begin
            r = 32'sh7FFFFFFF;
        end else if (v < -66'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // Clamp a duty value to the legal motor range.
    function automatic logic [20:0] duty_clamp(input logic signed [25:0] v);
        logic [20:0] r;
        if (v > $signed({5'd0, DUTY_MAX})) begin
            r = DUTY_MAX;
        end else if (v < $signed({5'd0, DUTY_MIN})) begin
            r = DUTY_MIN;
        end else begin
            r = v[20:0];
        end
        return r;
    endfunction

endpackage

@@ rtl/apm_mul.sv @@
// ----------------------------------------------------------------------------
// Attitude PD mixer shared multiplier
// Signed multiplier with a registered product, time-shared by the sequencer.
// ----------------------------------------------------------------------------
module apm_mul (
    input  logic                                 aclk,
    input  logic signed [apm_pkg::MUL_A_W-1:0]  a,
    input  logic signed [apm_pkg::MUL_B_W-1:0]  b,
    output logic signed [apm_pkg::MUL_P_W-1:0]  p
);

    logic signed [apm_pkg::MUL_P_W-1:0] p_reg;

    always_ff @(posedge aclk) begin
        p_reg <= apm_pkg::MUL_P_W'(a) * apm_pkg::MUL_P_W'(b);
    end

    assign p = p_reg;

endmodule

@@ rtl/apm_tilt.sv @@
// ----------------------------------------------------------------------------
// Attitude PD mixer tilt unit
// Bit-serial square root followed by a vectoring CORDIC that returns
// atan(256 * num / sqrt(radicand)) in degrees.
// ----------------------------------------------------------------------------
module apm_tilt #(
    parameter int ANGLE_FRAC_BITS = apm_pkg::ANGLE_FRAC_BITS_DEF,
    parameter int CORDIC_STEPS    = apm_pkg::CORDIC_STEPS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  apm_pkg::tilt_req_t req,
    output apm_pkg::tilt_rsp_t rsp
);

    localparam int ITERS = (CORDIC_STEPS < apm_pkg::TABLE_LEN) ?
                           CORDIC_STEPS : apm_pkg::TABLE_LEN;
    localparam int RSH   = 24 - ANGLE_FRAC_BITS;
    localparam int HALF  = (RSH == 0) ? 0 : (1 << (RSH - 1));
    localparam int CW    = apm_pkg::CORDIC_W;
    localparam int ZW    = apm_pkg::ZW;
    localparam int RW    = apm_pkg::RAD_W;
    localparam int SW    = apm_pkg::STEP_W;

    apm_pkg::tilt_state_t state_reg, state_next;

    logic        [SW-1:0] step_reg;
    logic        [RW-1:0] n_reg, res_reg, bit_reg;
    logic signed [CW-1:0] x_reg, y_reg;
    logic signed [ZW-1:0] z_reg;

    logic        [RW-1:0] trial, n_new, res_new;
    logic                 ge;
    logic signed [CW-1:0] xs, ys, x_new, y_new;
    logic signed [ZW-1:0] ang, z_new;
    logic signed [ZW:0]   z_round;
    logic                 sqrt_last, cordic_last;

    // One square-root bit per cycle.
    always_comb begin
        trial   = res_reg + bit_reg;
        ge      = (n_reg >= trial);
        n_new   = ge ? (n_reg - trial) : n_reg;
        res_new = ge ? ((res_reg >> 1) + bit_reg) : (res_reg >> 1);
    end

    // One CORDIC rotation per cycle.
    always_comb begin
        xs  = x_reg >>> step_reg;
        ys  = y_reg >>> step_reg;
        ang = ZW'(apm_pkg::atan_deg_q24(step_reg));
        if (y_reg > 0) begin
            x_new = x_reg + ys;
            y_new = y_reg - xs;
            z_new = z_reg + ang;
        end else begin
            x_new = x_reg - ys;
            y_new = y_reg + xs;
            z_new = z_reg - ang;
        end
    end

    assign sqrt_last   = (step_reg == SW'(apm_pkg::SQRT_STEPS - 1));
    assign cordic_last = (step_reg == SW'(ITERS - 1));

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            apm_pkg::T_IDLE: begin
                if (req.start) begin
                    state_next = (req.num == 16'sd0) ? apm_pkg::T_DONE : apm_pkg::T_SQRT;
                end
            end
            apm_pkg::T_SQRT: begin
                if (sqrt_last) begin
                    state_next = apm_pkg::T_CORDIC;
                end
            end
            apm_pkg::T_CORDIC: begin
                if (cordic_last) begin
                    state_next = apm_pkg::T_DONE;
                end
            end
            apm_pkg::T_DONE: begin
                state_next = apm_pkg::T_IDLE;
            end
            default: begin
                state_next = apm_pkg::T_IDLE;
            end
        endcase
    end

    always_comb begin
        z_round   = (ZW+1)'(z_reg) + (ZW+1)'(HALF);
        rsp.done  = (state_reg == apm_pkg::T_DONE);
        rsp.angle = ZW'(z_round >>> RSH);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= apm_pkg::T_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            apm_pkg::T_IDLE: begin
                if (req.start) begin
                    n_reg    <= req.radicand;
                    res_reg  <= '0;
                    bit_reg  <= RW'(1) << (RW - 2);
                    y_reg    <= CW'($signed(req.num)) <<< 8;
                    z_reg    <= '0;
                    step_reg <= '0;
                end
            end
            apm_pkg::T_SQRT: begin
                n_reg   <= n_new;
                res_reg <= res_new;
                bit_reg <= bit_reg >> 2;
                if (sqrt_last) begin
                    x_reg    <= CW'(res_new);
                    step_reg <= '0;
                end else begin
                    step_reg <= step_reg + SW'(1);
                end
            end
            apm_pkg::T_CORDIC: begin
                x_reg    <= x_new;
                y_reg    <= y_new;
                z_reg    <= z_new;
                step_reg <= step_reg + SW'(1);
            end
            default: begin
            end
        endcase
    end

endmodule

@@ rtl/quad_attitude_pd_mixer_core.sv @@
// ----------------------------------------------------------------------------
// Quad attitude PD mixer core
// Complementary-filter attitude estimator with a PD controller and a
// four-motor duty mixer, built around one shared multiplier.
// ----------------------------------------------------------------------------
// Usage:
// The s_ channel takes one raw gyro and accelerometer sample per transfer.
// The block updates its pitch and roll estimates and, once the warm-up
// count has passed, sends one set of four motor duties on the m_ channel.
// During warm-up a sample produces no result.
// The cfg channel writes one register per transfer; cfg_ready is always
// high. The user must see that registers are written only while the block
// is idle; the block itself does not enforce this. Each of the two tilt
// angles spends a start step, the bit-serial square root, the CORDIC and a
// done state; a zero numerator skips the root and the CORDIC. The rest is
// the multiplier sequence. One sample is processed at a time, so s_ready is
// high only while the sequencer is idle, and no new sample is taken before
// the sequencer is through with the last one.
// A result waits in the output register while the receiver stalls; the
// next sample is accepted meanwhile, and its result is held inside until
// the output register is free.
// Reset clears the angle estimates, previous errors and warm-up count and
// restores the register defaults.
// ----------------------------------------------------------------------------
module quad_attitude_pd_mixer_core #(
    parameter int ANGLE_FRAC_BITS = apm_pkg::ANGLE_FRAC_BITS_DEF,
    parameter int CORDIC_STEPS    = apm_pkg::CORDIC_STEPS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,

    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [15:0] s_gyro_x,
    input  logic signed [15:0] s_gyro_y,
    input  logic signed [15:0] s_accel_x,
    input  logic signed [15:0] s_accel_y,
    input  logic signed [15:0] s_accel_z,

    output logic               m_valid,
    input  logic               m_ready,
    output logic [20:0]        m_motor_one_duty,
    output logic [20:0]        m_motor_two_duty,
    output logic [20:0]        m_motor_three_duty,
    output logic [20:0]        m_motor_four_duty,

    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [20:0]        cfg_data
);

    localparam int AW   = apm_pkg::MUL_A_W;
    localparam int BW   = apm_pkg::MUL_B_W;
    localparam int PW   = apm_pkg::MUL_P_W;
    localparam int ZW   = apm_pkg::ZW;
    // Gyro increments are rounded from Q32 down to the angle format.
    localparam int GSH  = 32 - ANGLE_FRAC_BITS;
    localparam int GHALF = 1 << (GSH - 1);
    // The PD sum is in Q(F+24).
    localparam int TSH  = ANGLE_FRAC_BITS + 24;

    // Configuration registers.
    logic [15:0] prop_gain_reg, deriv_gain_reg, mix_gain_reg;
    logic [20:0] base_throttle_reg;
    logic [7:0]  warmup_items_reg;

    // Filter and controller state.
    logic signed [31:0] pitch_reg, roll_reg;
    logic signed [31:0] prev_pitch_reg, prev_roll_reg;
    logic [7:0]         warm_cnt_reg;

    // Working registers for one sample.
    apm_pkg::ctl_state_t state_reg, state_next;
    logic signed [15:0] gx_reg, gy_reg, ax_reg, ay_reg, az_reg;
    logic [30:0]        sqa_reg, sqb_reg, sqz_reg;
    logic signed [ZW-1:0] pa_reg, ra_reg;
    logic signed [PW-1:0] acc_reg, pk_reg;
    logic signed [31:0] err_pitch_reg, err_roll_reg;
    logic               axis_reg;
    logic signed [44:0] dk_reg;
    logic               neg_reg;
    logic [65:0]        mag_reg;
    logic signed [7:0]  term_pitch_reg, term_roll_reg;
    logic [20:0]        d1_reg, d2_reg, d3_reg, d4_reg;
    logic [20:0]        o1_reg, o2_reg, o3_reg, o4_reg;
    logic               m_valid_reg;

    // Shared multiplier.
    logic signed [AW-1:0] mul_a;
    logic signed [BW-1:0] mul_b;
    logic signed [PW-1:0] p;

    apm_pkg::tilt_req_t tilt_req;
    apm_pkg::tilt_rsp_t tilt_rsp;

    logic signed [PW-1:0] g_round;
    logic signed [31:0]   angle_sel, gyro_angle, blend_angle;
    logic signed [65:0]   blend_sum, v_sum;
    logic signed [31:0]   err_sel, prev_sel;
    logic signed [44:0]   dk_clamp;
    logic [65:0]          shifted;
    logic [6:0]           tmag;
    logic signed [7:0]    term_new;
    logic signed [25:0]   th, mix_prod;
    logic                 fire, out_free;

    apm_mul u_mul (
        .aclk (aclk),
        .a    (mul_a),
        .b    (mul_b),
        .p    (p)
    );

    apm_tilt #(
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
        .CORDIC_STEPS    (CORDIC_STEPS)
    ) u_tilt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (tilt_req),
        .rsp     (tilt_rsp)
    );

    assign cfg_ready = 1'b1;
    assign out_free  = !m_valid_reg || m_ready;
    assign fire      = (warm_cnt_reg >= warmup_items_reg);

    // Datapath arithmetic around the multiplier product.
    always_comb begin
        g_round    = (p + PW'(GHALF)) >>> GSH;
        angle_sel  = (state_reg == apm_pkg::C_GY) ? pitch_reg : roll_reg;
        gyro_angle = apm_pkg::sat32(66'(angle_sel) + 66'(g_round));

        blend_sum   = (66'(acc_reg) + 66'(p) + 66'sd32768) >>> 16;
        blend_angle = apm_pkg::sat32(blend_sum);

        err_sel  = axis_reg ? err_pitch_reg : err_roll_reg;
        prev_sel = axis_reg ? prev_pitch_reg : prev_roll_reg;

        // The derivative product is limited to plus or minus 2^43.
        if (p > $signed(PW'(1) <<< 43)) begin
            dk_clamp = 45'sd1 <<< 43;
        end else if (p < -$signed(PW'(1) <<< 43)) begin
            dk_clamp = -(45'sd1 <<< 43);
        end else begin
            dk_clamp = p[44:0];
        end

        v_sum = (66'(pk_reg) <<< 12) - 66'(p);

        // Truncate toward zero, then limit the term magnitude.
        shifted = mag_reg >> TSH;
        tmag    = (shifted > 66'(apm_pkg::TERM_LIMIT)) ? apm_pkg::TERM_LIMIT
                                                        : shifted[6:0];
        term_new = neg_reg ? -$signed({1'b0, tmag}) : $signed({1'b0, tmag});

        th       = $signed({5'd0, base_throttle_reg});
        mix_prod = p[25:0];
    end

    // Sequencer next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            apm_pkg::C_IDLE: if (s_valid) state_next = apm_pkg::C_GX;
            apm_pkg::C_GX:   state_next = apm_pkg::C_GY;
            apm_pkg::C_GY:   state_next = apm_pkg::C_GYW;
            apm_pkg::C_GYW:  state_next = apm_pkg::C_S1;
            apm_pkg::C_S1:   state_next = apm_pkg::C_S2;
            apm_pkg::C_S2:   state_next = apm_pkg::C_S3;
            apm_pkg::C_S3:   state_next = apm_pkg::C_S4;
            apm_pkg::C_S4:   state_next = apm_pkg::C_TP;
            apm_pkg::C_TP:   state_next = apm_pkg::C_TPW;
            apm_pkg::C_TPW:  if (tilt_rsp.done) state_next = apm_pkg::C_TR;
            apm_pkg::C_TR:   state_next = apm_pkg::C_TRW;
            apm_pkg::C_TRW:  if (tilt_rsp.done) state_next = apm_pkg::C_B1;
            apm_pkg::C_B1:   state_next = apm_pkg::C_B2;
            apm_pkg::C_B2:   state_next = apm_pkg::C_B3;
            apm_pkg::C_B3:   state_next = apm_pkg::C_B4;
            apm_pkg::C_B4:   state_next = apm_pkg::C_B5;
            apm_pkg::C_B5:   state_next = fire ? apm_pkg::C_ERR : apm_pkg::C_IDLE;
            apm_pkg::C_ERR:  state_next = apm_pkg::C_D1;
            apm_pkg::C_D1:   state_next = apm_pkg::C_D2;
            apm_pkg::C_D2:   state_next = apm_pkg::C_D3;
            apm_pkg::C_D3:   state_next = apm_pkg::C_D4;
            apm_pkg::C_D4:   state_next = apm_pkg::C_D5;
            apm_pkg::C_D5:   state_next = axis_reg ? apm_pkg::C_M1 : apm_pkg::C_D1;
            apm_pkg::C_M1:   state_next = apm_pkg::C_M2;
            apm_pkg::C_M2:   state_next = apm_pkg::C_M3;
            apm_pkg::C_M3:   state_next = apm_pkg::C_OUT;
            apm_pkg::C_OUT:  if (out_free) state_next = apm_pkg::C_IDLE;
            default:         state_next = apm_pkg::C_IDLE;
        endcase
    end

    // Sequencer outputs: handshake, multiplier operands and tilt requests.
    always_comb begin
        s_ready           = (state_reg == apm_pkg::C_IDLE);
        mul_a             = '0;
        mul_b             = '0;
        tilt_req.start    = 1'b0;
        tilt_req.num      = ax_reg;
        tilt_req.radicand = {({1'b0, sqa_reg} + {1'b0, sqz_reg}), 16'd0};
        case (state_reg)
            apm_pkg::C_GX: begin
                mul_a = AW'(apm_pkg::GYRO_STEP);
                mul_b = BW'(gx_reg);
            end
            apm_pkg::C_GY: begin
                mul_a = AW'(apm_pkg::GYRO_STEP);
                mul_b = BW'(gy_reg);
            end
            apm_pkg::C_S1: begin
                mul_a = AW'(ay_reg);
                mul_b = BW'(ay_reg);
            end
            apm_pkg::C_S2: begin
                mul_a = AW'(ax_reg);
                mul_b = BW'(ax_reg);
            end
            apm_pkg::C_S3: begin
                mul_a = AW'(az_reg);
                mul_b = BW'(az_reg);
            end
            apm_pkg::C_TP: begin
                tilt_req.start = 1'b1;
            end
            apm_pkg::C_TR: begin
                tilt_req.start    = 1'b1;
                tilt_req.num      = ay_reg;
                tilt_req.radicand = {({1'b0, sqb_reg} + {1'b0, sqz_reg}), 16'd0};
            end
            apm_pkg::C_B1: begin
                mul_a = AW'(pitch_reg);
                mul_b = BW'(apm_pkg::BLEND_OLD);
            end
            apm_pkg::C_B2: begin
                mul_a = AW'(pa_reg);
                mul_b = BW'(apm_pkg::BLEND_NEW);
            end
            apm_pkg::C_B3: begin
                mul_a = AW'(roll_reg);
                mul_b = BW'(apm_pkg::BLEND_OLD);
            end
            apm_pkg::C_B4: begin
                mul_a = AW'(ra_reg);
                mul_b = BW'(apm_pkg::BLEND_NEW);
            end
            apm_pkg::C_D1: begin
                mul_a = AW'(33'(err_sel) - 33'(prev_sel));
                mul_b = BW'(deriv_gain_reg);
            end
            apm_pkg::C_D2: begin
                mul_a = AW'(err_sel);
                mul_b = BW'(prop_gain_reg);
            end
            apm_pkg::C_D3: begin
                mul_a = dk_reg;
                mul_b = BW'(apm_pkg::INV_DT);
            end
            apm_pkg::C_M1: begin
                mul_a = AW'(mix_gain_reg);
                mul_b = BW'(term_pitch_reg);
            end
            apm_pkg::C_M2: begin
                mul_a = AW'(mix_gain_reg);
                mul_b = BW'(term_roll_reg);
            end
            default: begin
            end
        endcase
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= apm_pkg::C_IDLE;
            m_valid_reg       <= 1'b0;
            prop_gain_reg     <= apm_pkg::PROP_GAIN_RST;
            deriv_gain_reg    <= apm_pkg::DERIV_GAIN_RST;
            base_throttle_reg <= apm_pkg::BASE_THROTTLE_RST;
            mix_gain_reg      <= apm_pkg::MIX_GAIN_RST;
            warmup_items_reg  <= apm_pkg::WARMUP_ITEMS_RST;
            pitch_reg         <= '0;
            roll_reg          <= '0;
            prev_pitch_reg    <= '0;
            prev_roll_reg     <= '0;
            warm_cnt_reg      <= '0;
        end else begin
            state_reg <= state_next;

            if (cfg_valid) begin
                case (cfg_index)
                    apm_pkg::REG_PROP_GAIN:     prop_gain_reg     <= cfg_data[15:0];
                    apm_pkg::REG_DERIV_GAIN:    deriv_gain_reg    <= cfg_data[15:0];
                    apm_pkg::REG_BASE_THROTTLE: base_throttle_reg <= cfg_data;
                    apm_pkg::REG_MIX_GAIN:      mix_gain_reg      <= cfg_data[15:0];
                    apm_pkg::REG_WARMUP_ITEMS:  warmup_items_reg  <= cfg_data[7:0];
                    default: begin
                    end
                endcase
            end

            if (state_reg == apm_pkg::C_OUT && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                apm_pkg::C_GY:  pitch_reg <= gyro_angle;
                apm_pkg::C_GYW: roll_reg  <= gyro_angle;
                apm_pkg::C_B3:  pitch_reg <= blend_angle;
                apm_pkg::C_B5: begin
                    roll_reg <= blend_angle;
                    if (warm_cnt_reg != 8'hFF) begin
                        warm_cnt_reg <= warm_cnt_reg + 8'd1;
                    end
                end
                apm_pkg::C_D5: begin
                    if (axis_reg) begin
                        prev_pitch_reg <= err_pitch_reg;
                    end else begin
                        prev_roll_reg <= err_roll_reg;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        case (state_reg)
            apm_pkg::C_IDLE: begin
                gx_reg <= s_gyro_x;
                gy_reg <= s_gyro_y;
                ax_reg <= s_accel_x;
                ay_reg <= s_accel_y;
                az_reg <= s_accel_z;
            end
            apm_pkg::C_S2:  sqa_reg <= p[30:0];
            apm_pkg::C_S3:  sqb_reg <= p[30:0];
            apm_pkg::C_S4:  sqz_reg <= p[30:0];
            apm_pkg::C_TPW: pa_reg  <= tilt_rsp.angle;
            apm_pkg::C_TRW: ra_reg  <= tilt_rsp.angle;
            apm_pkg::C_B2:  acc_reg <= p;
            apm_pkg::C_B4:  acc_reg <= p;
            apm_pkg::C_ERR: begin
                err_roll_reg  <= apm_pkg::sat32(-66'(roll_reg));
                err_pitch_reg <= apm_pkg::sat32(-66'(pitch_reg));
                axis_reg      <= 1'b0;
            end
            apm_pkg::C_D2: dk_reg <= dk_clamp;
            apm_pkg::C_D3: pk_reg <= p;
            apm_pkg::C_D4: begin
                neg_reg <= v_sum[65];
                mag_reg <= v_sum[65] ? 66'(-v_sum) : 66'(v_sum);
            end
            apm_pkg::C_D5: begin
                if (axis_reg) begin
                    term_pitch_reg <= term_new;
                end else begin
                    term_roll_reg <= term_new;
                end
                axis_reg <= 1'b1;
            end
            apm_pkg::C_M2: begin
                d1_reg <= apm_pkg::duty_clamp(th + mix_prod);
                d2_reg <= apm_pkg::duty_clamp(th - mix_prod);
            end
            apm_pkg::C_M3: begin
                d3_reg <= apm_pkg::duty_clamp(th + mix_prod);
                d4_reg <= apm_pkg::duty_clamp(th - mix_prod);
            end
            apm_pkg::C_OUT: begin
                if (out_free) begin
                    o1_reg <= d1_reg;
                    o2_reg <= d2_reg;
                    o3_reg <= d3_reg;
                    o4_reg <= d4_reg;
                end
            end
            default: begin
            end
        endcase
    end

    assign m_valid            = m_valid_reg;
    assign m_motor_one_duty   = o1_reg;
    assign m_motor_two_duty   = o2_reg;
    assign m_motor_three_duty = o3_reg;
    assign m_motor_four_duty  = o4_reg;

endmodule
